// ===== hw/rtl/pls_pkg.sv =====
// shared types and constants for the positional list store
// no dependencies; used by every module under hw/rtl
package pls_pkg;

  localparam int DEPTH  = 128;
  localparam int CNT_W  = 8;
  localparam int DATA_W = 32;
  localparam int GRP    = 8;
  localparam int GIDX_W = 3;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int NG_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NPAD   = NGRP * GRP;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } stat_t;

  // broadcast to every cell in the accept cycle
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              tap;
    logic              srch;
    logic [CNT_W-1:0]  pos0;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

  // per-group reduction result
  typedef struct packed {
    logic              any;
    logic [GIDX_W-1:0] first;
    logic [DATA_W-1:0] data;
  } grp_res_t;

endpackage

// ===== hw/rtl/pls_cell.sv =====
// one list entry cell: shifts with its neighbors, taps and compares
// depends on pls_pkg
module pls_cell (
  input  logic                      clk,
  input  logic [pls_pkg::CNT_W-1:0] idx,
  input  pls_pkg::cell_ctl_t        ctl,
  input  logic [pls_pkg::DATA_W-1:0] left_i,
  input  logic [pls_pkg::DATA_W-1:0] right_i,
  output logic [pls_pkg::DATA_W-1:0] entry_o,
  output logic [pls_pkg::DATA_W-1:0] tap_o,
  output logic                      hit_o
);

  logic [pls_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic [pls_pkg::DATA_W-1:0] tap_r, tap_nxt;
  logic                       hit_r, hit_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && idx > ctl.pos0) begin
      entry_nxt = left_i;
    end else if (ctl.ins && idx == ctl.pos0) begin
      entry_nxt = ctl.key;
    end else if (ctl.del && idx >= ctl.pos0) begin
      entry_nxt = right_i;
    end
    tap_nxt = (ctl.tap && idx == ctl.pos0) ? entry_r : '0;
    hit_nxt = ctl.srch && (idx < ctl.cnt) && (entry_r == ctl.key);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tap_r   <= tap_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry_o = entry_r;
  assign tap_o   = tap_r;
  assign hit_o   = hit_r;

endmodule

// ===== hw/rtl/pls_group.sv =====
// registered reduction over one group of cells: first hit and tapped value
// depends on pls_pkg
module pls_group (
  input  logic                       clk,
  input  logic [pls_pkg::DATA_W-1:0] tap_i [pls_pkg::GRP],
  input  logic                       hit_i [pls_pkg::GRP],
  output pls_pkg::grp_res_t          res_o
);

  pls_pkg::grp_res_t res_r, res_nxt;

  always_comb begin
    res_nxt = '0;
    for (int i = pls_pkg::GRP - 1; i >= 0; i--) begin
      res_nxt.data = res_nxt.data | tap_i[i];
      if (hit_i[i]) begin
        res_nxt.any   = 1'b1;
        res_nxt.first = pls_pkg::GIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

// ===== hw/rtl/positional_list_store_unit.sv =====
// top level of the positional list store: request decode, cell chain,
// group reduction and result register; depends on pls_pkg, pls_cell, pls_group
//
// An ordered list of up to DEPTH signed 32-bit values held in a chain of
// cells, one entry per cell. Insert and delete move every later entry by one
// cell in the accept cycle, each cell taking its neighbor's value. Delete and
// read tap the addressed cell, and search compares the key in every cell at
// once; the tapped value and the first hit are then reduced in two registered
// stages (groups of eight cells, then across groups). One request is in work
// at a time: the tap and hit, group and result registers lie between the
// accept and the offered result, and the next request is taken in the cycle
// after the result is taken. Entries hold no reset value; only entries below
// the count are ever read.
module positional_list_store_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_cmd,
  input  logic [pls_pkg::CNT_W-1:0]         in_position,
  input  logic signed [pls_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic signed [pls_pkg::DATA_W-1:0] out_data_out,
  output logic [pls_pkg::CNT_W-1:0]         out_found_position,
  output logic [pls_pkg::CNT_W-1:0]         out_entry_count
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TAP  = 4'b0010,
    ST_GRP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [pls_pkg::CNT_W-1:0] count_r, count_nxt;

  // request bookkeeping carried down the reduction stages
  logic [2:0] stat_r, stat_nxt;
  logic       srch_r, srch_nxt;

  // result register
  logic [2:0]                  res_stat_r, res_stat_nxt;
  logic [pls_pkg::DATA_W-1:0]  res_data_r, res_data_nxt;
  logic [pls_pkg::CNT_W-1:0]   res_found_r, res_found_nxt;

  pls_pkg::cell_ctl_t ctl;
  logic               accept;
  logic [pls_pkg::CNT_W:0] cnt_plus1;

  logic [pls_pkg::DATA_W-1:0] ent [pls_pkg::DEPTH];
  logic [pls_pkg::DATA_W-1:0] tap [pls_pkg::NPAD];
  logic                       hit [pls_pkg::NPAD];
  pls_pkg::grp_res_t          grp [pls_pkg::NGRP];

  logic                      any_all;
  logic [pls_pkg::NG_W-1:0]  first_g;
  logic [pls_pkg::GIDX_W-1:0] first_l;
  logic [pls_pkg::DATA_W-1:0] data_all;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cnt_plus1 = {1'b0, count_r} + 1'b1;

  // request decode against the current count
  always_comb begin
    ctl       = '0;
    ctl.pos0  = in_position - 1'b1;
    ctl.cnt   = count_r;
    ctl.key   = in_value;
    count_nxt = count_r;
    stat_nxt  = stat_r;
    srch_nxt  = srch_r;
    if (accept) begin
      stat_nxt = pls_pkg::STAT_OK;
      srch_nxt = 1'b0;
      case (in_cmd)
        pls_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        pls_pkg::CMD_INSERT: begin
          if ({1'b0, count_r} >= (pls_pkg::CNT_W + 1)'(pls_pkg::DEPTH)) begin
            stat_nxt = pls_pkg::STAT_FULL;
          end else if (in_position == '0 || {1'b0, in_position} > cnt_plus1) begin
            stat_nxt = pls_pkg::STAT_BADPOS;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        pls_pkg::CMD_DELETE: begin
          if (count_r == '0) begin
            stat_nxt = pls_pkg::STAT_EMPTY;
          end else if (in_position == '0 || in_position > count_r) begin
            stat_nxt = pls_pkg::STAT_BADPOS;
          end else begin
            ctl.del   = 1'b1;
            ctl.tap   = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        pls_pkg::CMD_SEARCH: begin
          if (count_r == '0) begin
            stat_nxt = pls_pkg::STAT_EMPTY;
          end else begin
            ctl.srch = 1'b1;
            srch_nxt = 1'b1;
          end
        end
        pls_pkg::CMD_READ: begin
          if (count_r == '0) begin
            stat_nxt = pls_pkg::STAT_EMPTY;
          end else if (in_position == '0 || in_position > count_r) begin
            stat_nxt = pls_pkg::STAT_BADPOS;
          end else begin
            ctl.tap = 1'b1;
          end
        end
        default: begin
          // unused codes leave everything as is
        end
      endcase
    end
  end

  // chain of cells, each fed by both neighbors
  for (genvar k = 0; k < pls_pkg::DEPTH; k++) begin : g_cell
    logic [pls_pkg::DATA_W-1:0] left_v, right_v;
    if (k == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = ent[k-1];
    end
    if (k == pls_pkg::DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = ent[k+1];
    end
    pls_cell u_cell (
      .clk     (clk),
      .idx     (pls_pkg::CNT_W'(k)),
      .ctl     (ctl),
      .left_i  (left_v),
      .right_i (right_v),
      .entry_o (ent[k]),
      .tap_o   (tap[k]),
      .hit_o   (hit[k])
    );
  end

  // pad the last group with idle lanes
  for (genvar k = pls_pkg::DEPTH; k < pls_pkg::NPAD; k++) begin : g_pad
    assign tap[k] = '0;
    assign hit[k] = 1'b0;
  end

  for (genvar g = 0; g < pls_pkg::NGRP; g++) begin : g_grp
    pls_group u_grp (
      .clk   (clk),
      .tap_i (tap[g*pls_pkg::GRP +: pls_pkg::GRP]),
      .hit_i (hit[g*pls_pkg::GRP +: pls_pkg::GRP]),
      .res_o (grp[g])
    );
  end

  // final reduction across groups, lowest hit wins
  always_comb begin
    any_all  = 1'b0;
    first_g  = '0;
    first_l  = '0;
    data_all = '0;
    for (int g = pls_pkg::NGRP - 1; g >= 0; g--) begin
      data_all = data_all | grp[g].data;
      if (grp[g].any) begin
        any_all = 1'b1;
        first_g = pls_pkg::NG_W'(g);
        first_l = grp[g].first;
      end
    end
  end

  always_comb begin
    res_stat_nxt  = res_stat_r;
    res_data_nxt  = res_data_r;
    res_found_nxt = res_found_r;
    if (state_r == ST_GRP) begin
      res_stat_nxt  = stat_r;
      res_data_nxt  = data_all;
      res_found_nxt = '0;
      if (srch_r) begin
        if (any_all) begin
          res_stat_nxt  = pls_pkg::STAT_OK;
          res_found_nxt = pls_pkg::CNT_W'({first_g, first_l}) + 1'b1;
        end else begin
          res_stat_nxt  = pls_pkg::STAT_NOTFOUND;
        end
      end
    end
  end

  // request sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_TAP;
        end
      end
      ST_TAP: begin
        state_nxt = ST_GRP;
      end
      ST_GRP: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r      <= stat_nxt;
    srch_r      <= srch_nxt;
    res_stat_r  <= res_stat_nxt;
    res_data_r  <= res_data_nxt;
    res_found_r <= res_found_nxt;
  end

  assign out_valid          = (state_r == ST_OUT);
  assign out_status         = res_stat_r;
  assign out_data_out       = res_data_r;
  assign out_found_position = res_found_r;
  assign out_entry_count    = count_r;

endmodule

// ===== dv/pls_list_checker.sv =====
// result checker for the positional list store: keeps its own copy of the list,
// predicts one result per accepted request and compares the results in order
// depends on pls_pkg for the command and status codes and the widths
module pls_list_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [2:0]                        in_cmd,
  input  logic [pls_pkg::CNT_W-1:0]         in_position,
  input  logic signed [pls_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [2:0]                        out_status,
  input  logic signed [pls_pkg::DATA_W-1:0] out_data_out,
  input  logic [pls_pkg::CNT_W-1:0]         out_found_position,
  input  logic [pls_pkg::CNT_W-1:0]         out_entry_count,
  output int                                failures,
  output int                                pending
);

  typedef struct packed {
    logic [2:0]                 status;
    logic [pls_pkg::DATA_W-1:0] data;
    logic [pls_pkg::CNT_W-1:0]  found;
    logic [pls_pkg::CNT_W-1:0]  cnt;
  } list_result_t;

  logic [pls_pkg::DATA_W-1:0] entries [pls_pkg::DEPTH];
  int                         length;
  int                         fail_tally;
  list_result_t               expected_q [$];

  // applies one request to the shadow list and returns its result
  function automatic list_result_t apply_request(input logic [2:0] c,
                                                 input logic [pls_pkg::CNT_W-1:0] p,
                                                 input logic [pls_pkg::DATA_W-1:0] v);
    list_result_t r;
    int           pos;
    int           i;
    r   = '0;
    pos = int'(p);
    case (c)
      pls_pkg::CMD_CLEAR: begin
        length = 0;
      end
      pls_pkg::CMD_INSERT: begin
        if (length >= pls_pkg::DEPTH) begin
          r.status = pls_pkg::STAT_FULL;
        end else if (pos < 1 || pos > length + 1) begin
          r.status = pls_pkg::STAT_BADPOS;
        end else begin
          for (i = length; i >= pos; i--) entries[i] = entries[i-1];
          entries[pos-1] = v;
          length++;
        end
      end
      pls_pkg::CMD_DELETE: begin
        if (length == 0) begin
          r.status = pls_pkg::STAT_EMPTY;
        end else if (pos < 1 || pos > length) begin
          r.status = pls_pkg::STAT_BADPOS;
        end else begin
          r.data = entries[pos-1];
          for (i = pos - 1; i + 1 < length; i++) entries[i] = entries[i+1];
          length--;
        end
      end
      pls_pkg::CMD_SEARCH: begin
        if (length == 0) begin
          r.status = pls_pkg::STAT_EMPTY;
        end else begin
          r.status = pls_pkg::STAT_NOTFOUND;
          for (i = 0; i < length; i++) begin
            if (r.found == '0 && entries[i] == v) begin
              r.found  = pls_pkg::CNT_W'(i + 1);
              r.status = pls_pkg::STAT_OK;
            end
          end
        end
      end
      pls_pkg::CMD_READ: begin
        if (length == 0) begin
          r.status = pls_pkg::STAT_EMPTY;
        end else if (pos < 1 || pos > length) begin
          r.status = pls_pkg::STAT_BADPOS;
        end else begin
          r.data = entries[pos-1];
        end
      end
      default: begin
      end
    endcase
    r.cnt = pls_pkg::CNT_W'(length);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      length     = 0;
      fail_tally = 0;
      expected_q.delete();
    end else begin
      // results first, so a request taken at the same edge queues behind
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: status %0d data %0d",
                 out_status, out_data_out);
          fail_tally++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_tally++;
          end
          if (out_data_out !== want.data) begin
            $error("data_out: expected %0d, got %0d", $signed(want.data), out_data_out);
            fail_tally++;
          end
          if (out_found_position !== want.found) begin
            $error("found_position: expected %0d, got %0d", want.found,
                   out_found_position);
            fail_tally++;
          end
          if (out_entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, out_entry_count);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_request(in_cmd, in_position, in_value));
      end
    end
    failures <= fail_tally;
    pending  <= expected_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for positional_list_store_unit: clock, reset, request stimulus
// and the verdict; depends on pls_pkg, the block and pls_list_checker
module tb_top;

  logic                              clk          = 1'b0;
  logic                              rst_n        = 1'b0;
  logic                              in_valid     = 1'b0;
  logic [2:0]                        in_cmd       = '0;
  logic [pls_pkg::CNT_W-1:0]         in_position  = '0;
  logic signed [pls_pkg::DATA_W-1:0] in_value     = '0;
  logic                              out_ready    = 1'b0;
  logic                              in_ready;
  logic                              out_valid;
  logic [2:0]                        out_status;
  logic signed [pls_pkg::DATA_W-1:0] out_data_out;
  logic [pls_pkg::CNT_W-1:0]         out_found_position;
  logic [pls_pkg::CNT_W-1:0]         out_entry_count;
  int                                failures;
  int                                pending;

  // idling odds in percent, changed per phase
  int send_idle  = 0;
  int recv_stall = 0;
  // list length as the stimulus sees it, used only to aim positions
  int fill       = 0;

  always #10 clk = ~clk;

  positional_list_store_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_data_out       (out_data_out),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

  pls_list_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_data_out       (out_data_out),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .failures           (failures),
    .pending            (pending)
  );

  // receiver side: stall at random with the odds of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // one request: optional idle cycles, then hold valid until taken
  task automatic send(input logic [2:0] c, input int p,
                      input logic [pls_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= c;
    in_position <= pls_pkg::CNT_W'(p);
    in_value    <= v;
    do @(posedge clk); while (!in_ready);
    // follow the length the block should now hold
    case (c)
      pls_pkg::CMD_CLEAR:  fill = 0;
      pls_pkg::CMD_INSERT: if (fill < pls_pkg::DEPTH && p >= 1 && p <= fill + 1) fill++;
      pls_pkg::CMD_DELETE: if (fill > 0 && p >= 1 && p <= fill) fill--;
      default: begin
      end
    endcase
  endtask

  // mostly legal positions, with the edges and the full 8-bit range mixed in
  function automatic int pick_position(input int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom_range(255);
    if (roll < 35) begin
      case ($urandom_range(3))
        0: return 0;
        1: return 1;
        2: return hi;
        default: return (hi + 1) % 256;
      endcase
    end
    return (hi == 0) ? 1 : $urandom_range(hi, 1);
  endfunction

  // a small pool of values makes search hits and duplicate keys common
  function automatic logic [pls_pkg::DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return pls_pkg::DATA_W'($urandom_range(15)) - pls_pkg::DATA_W'(8);
    if (roll < 60) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // grow phases push the list to full and beyond; the others churn it
  task automatic random_phase(input int items, input bit grow);
    int         roll;
    logic [2:0] c;
    repeat (items) begin
      roll = $urandom_range(99);
      if (grow) begin
        if (roll < 80)      c = pls_pkg::CMD_INSERT;
        else if (roll < 85) c = pls_pkg::CMD_DELETE;
        else if (roll < 93) c = pls_pkg::CMD_SEARCH;
        else if (roll < 98) c = pls_pkg::CMD_READ;
        else                c = 3'($urandom_range(7, 5));
      end else begin
        if (roll < 2)       c = pls_pkg::CMD_CLEAR;
        else if (roll < 40) c = pls_pkg::CMD_INSERT;
        else if (roll < 65) c = pls_pkg::CMD_DELETE;
        else if (roll < 82) c = pls_pkg::CMD_SEARCH;
        else if (roll < 97) c = pls_pkg::CMD_READ;
        else                c = 3'($urandom_range(7, 5));
      end
      send(c, pick_position((c == pls_pkg::CMD_INSERT) ? fill + 1 : fill), pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list cases first
    send(pls_pkg::CMD_CLEAR,  0, 32'd0);
    send(pls_pkg::CMD_SEARCH, 0, 32'd0);
    send(pls_pkg::CMD_DELETE, 1, 32'd0);
    send(pls_pkg::CMD_READ,   1, 32'd0);
    // insert outside 1..count+1
    send(pls_pkg::CMD_INSERT, 0, 32'd9);
    send(pls_pkg::CMD_INSERT, 2, 32'd9);
    // build a short list that holds both value extremes
    send(pls_pkg::CMD_INSERT, 1, 32'h8000_0000);
    send(pls_pkg::CMD_INSERT, 2, 32'h7fff_ffff);
    send(pls_pkg::CMD_INSERT, 1, 32'hffff_ffff);
    send(pls_pkg::CMD_INSERT, 2, 32'd5);
    send(pls_pkg::CMD_INSERT, 255, 32'd1);
    // read outside 1..count, then a good read of the last entry
    send(pls_pkg::CMD_READ, 0, 32'd0);
    send(pls_pkg::CMD_READ, 5, 32'd0);
    send(pls_pkg::CMD_READ, 255, 32'hffff_ffff);
    send(pls_pkg::CMD_READ, 4, 32'd0);
    // search hit, miss, and first of two matches
    send(pls_pkg::CMD_SEARCH, 0, 32'h7fff_ffff);
    send(pls_pkg::CMD_SEARCH, 0, 32'd123);
    send(pls_pkg::CMD_INSERT, 5, 32'd5);
    send(pls_pkg::CMD_SEARCH, 255, 32'd5);
    // delete outside the list, then from the middle and the front
    send(pls_pkg::CMD_DELETE, 0, 32'd0);
    send(pls_pkg::CMD_DELETE, 6, 32'd0);
    send(pls_pkg::CMD_DELETE, 2, 32'd0);
    send(pls_pkg::CMD_DELETE, 1, 32'd0);
    // unused command codes leave the list alone
    send(3'd5, 255, 32'hffff_ffff);
    send(3'd6, 1, 32'd0);
    send(3'd7, 2, 32'h5555_aaaa);

    // random: each idling mode once growing to full and once churning
    for (int ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      random_phase(230, (ph % 2) == 0);
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    recv_stall = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("positional_list_store_unit test passed");
    end else begin
      $display("positional_list_store_unit test failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #20_000_000;
    $display("positional_list_store_unit test failed");
    $finish;
  end

endmodule
